// ===== src/spxc_pkg.sv =====
// ----------------------------------------------------------------------------
// spxc_pkg: shared types and constants of the seeded permutation XOR cipher
// Sequencer states, permutation RAM request bundle, generator constants and
// the block multiplier ROM of 256 odd primes.
// ----------------------------------------------------------------------------
package spxc_pkg;

    localparam int PERM_AW     = 8;
    localparam int SWAP_CNT_W  = 12;   // 4096 draws per start item

    localparam logic       MODE_START = 1'b0;
    localparam logic [31:0] SEED_MULT = 32'h6C07_8965;
    localparam logic [31:0] GEN_INIT3 = 32'h03DF_95B3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_D_PRIME,
        ST_D_KEY
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [PERM_AW-1:0] rd_addr_a;
        logic [PERM_AW-1:0] rd_addr_b;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } perm_req_t;

    localparam logic [10:0] PRIME_ROM [256] = '{
        11'd3, 11'd5, 11'd7, 11'd11, 11'd13, 11'd17, 11'd19, 11'd23, 11'd29, 11'd31,
        11'd37, 11'd41, 11'd43, 11'd47, 11'd53, 11'd59, 11'd61, 11'd67, 11'd71, 11'd73,
        11'd79, 11'd83, 11'd89, 11'd97, 11'd101, 11'd103, 11'd107, 11'd109, 11'd113,
        11'd127, 11'd131, 11'd137, 11'd139, 11'd149, 11'd151, 11'd157,
        11'd163, 11'd167, 11'd173, 11'd179, 11'd181, 11'd191, 11'd193, 11'd197,
        11'd199, 11'd211, 11'd223, 11'd227, 11'd229, 11'd233, 11'd239,
        11'd241, 11'd251, 11'd257, 11'd263, 11'd269, 11'd271, 11'd277, 11'd281,
        11'd283, 11'd293, 11'd307, 11'd311, 11'd313, 11'd317, 11'd331,
        11'd337, 11'd347, 11'd349, 11'd353, 11'd359, 11'd367, 11'd373, 11'd379,
        11'd383, 11'd389, 11'd397, 11'd401, 11'd409, 11'd419, 11'd421,
        11'd431, 11'd433, 11'd439, 11'd443, 11'd449, 11'd457, 11'd461, 11'd463,
        11'd467, 11'd479, 11'd487, 11'd491, 11'd499, 11'd503, 11'd509,
        11'd521, 11'd523, 11'd541, 11'd547, 11'd557, 11'd563, 11'd569, 11'd571,
        11'd577, 11'd587, 11'd593, 11'd599, 11'd601, 11'd607, 11'd613,
        11'd617, 11'd619, 11'd631, 11'd641, 11'd643, 11'd647, 11'd653, 11'd659,
        11'd661, 11'd673, 11'd677, 11'd683, 11'd691, 11'd701, 11'd709,
        11'd719, 11'd727, 11'd733, 11'd739, 11'd743, 11'd751, 11'd757, 11'd761,
        11'd769, 11'd773, 11'd787, 11'd797, 11'd809, 11'd811, 11'd821,
        11'd823, 11'd827, 11'd829, 11'd839, 11'd853, 11'd857, 11'd859, 11'd863,
        11'd877, 11'd881, 11'd883, 11'd887, 11'd907, 11'd911, 11'd919,
        11'd929, 11'd937, 11'd941, 11'd947, 11'd953, 11'd967, 11'd971, 11'd977,
        11'd983, 11'd991, 11'd997, 11'd1009, 11'd1013, 11'd1019,
        11'd1021, 11'd1031, 11'd1033, 11'd1039, 11'd1049, 11'd1051, 11'd1061,
        11'd1063, 11'd1069, 11'd1087, 11'd1091, 11'd1093,
        11'd1097, 11'd1103, 11'd1109, 11'd1117, 11'd1123, 11'd1129, 11'd1151,
        11'd1153, 11'd1163, 11'd1171, 11'd1181, 11'd1187,
        11'd1193, 11'd1201, 11'd1213, 11'd1217, 11'd1223, 11'd1229, 11'd1231,
        11'd1237, 11'd1249, 11'd1259, 11'd1277, 11'd1279,
        11'd1283, 11'd1289, 11'd1291, 11'd1297, 11'd1301, 11'd1303, 11'd1307,
        11'd1319, 11'd1321, 11'd1327, 11'd1361, 11'd1367,
        11'd1373, 11'd1381, 11'd1399, 11'd1409, 11'd1423, 11'd1427, 11'd1429,
        11'd1433, 11'd1439, 11'd1447, 11'd1451, 11'd1453,
        11'd1459, 11'd1471, 11'd1481, 11'd1483, 11'd1487, 11'd1489, 11'd1493,
        11'd1499, 11'd1511, 11'd1523, 11'd1531, 11'd1543,
        11'd1549, 11'd1553, 11'd1559, 11'd1567, 11'd1571, 11'd1579, 11'd1583,
        11'd1597, 11'd1601, 11'd1607, 11'd1609, 11'd1613,
        11'd1619, 11'd1621
    };

endpackage

// ===== src/spxc_perm_ram.sv =====
// ----------------------------------------------------------------------------
// spxc_perm_ram: 256 x 8 permutation RAM
// One write port, two registered read ports. A valid bit per entry makes an
// unwritten entry read as its own address, so a clear restores identity.
// ----------------------------------------------------------------------------
module spxc_perm_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spxc_pkg::perm_req_t           req,
    output logic [7:0]                    rd_data_a,
    output logic [7:0]                    rd_data_b
);

    localparam int DEPTH = 1 << spxc_pkg::PERM_AW;

    logic [7:0]                  perm_mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [7:0]                  mem_a_reg;
    logic [7:0]                  mem_b_reg;
    logic                        vld_a_reg;
    logic                        vld_b_reg;
    logic [spxc_pkg::PERM_AW-1:0] addr_a_reg;
    logic [spxc_pkg::PERM_AW-1:0] addr_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            perm_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_a_reg  <= perm_mem[req.rd_addr_a];
            mem_b_reg  <= perm_mem[req.rd_addr_b];
            addr_a_reg <= req.rd_addr_a;
            addr_b_reg <= req.rd_addr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_a_reg <= valid_reg[req.rd_addr_a];
                vld_b_reg <= valid_reg[req.rd_addr_b];
            end
        end
    end

    // unwritten entries hold the identity value
    assign rd_data_a = vld_a_reg ? mem_a_reg : 8'(addr_a_reg);
    assign rd_data_b = vld_b_reg ? mem_b_reg : 8'(addr_b_reg);

endmodule

// ===== src/seeded_permutation_xor_cipher.sv =====
// ----------------------------------------------------------------------------
// seeded_permutation_xor_cipher: symmetric byte cipher on a shuffled table
// Start items seed a xorshift generator and shuffle the permutation RAM;
// data items are XORed with a keystream byte read from that table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: tuser is the mode (0 = start with seed, 1 = data).
//   tdata carries the seed in bits [31:0] and the data byte in [39:32].
//   Output channel m_*: one item per data item, the transformed byte.
// Sequencing:
//   A data item needs one RAM read for the key byte, and one more at
//   each 256-byte block start to select the block prime before the key
//   address is known.
//   A start item is accepted, derives three generator words from the seed
//   (one multiply each) and then makes 4096 draws. A draw of two unequal
//   bytes swaps both entries, written one after the other over the single
//   write port of the permutation RAM; a draw of equal bytes is counted.
// Reset: identity table, generator words, position and block prime zero.
// Stall: a result waits in the output register; a new item is still taken,
//   and its result holds in the last step until the register is free.
// ----------------------------------------------------------------------------
module seeded_permutation_xor_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] seed, [39:32] data_byte
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] out_byte
);

    spxc_pkg::state_t  state_reg, state_next;
    logic [31:0]       gen_reg [4];
    logic [31:0]       gen_next [4];
    logic [31:0]       seed_reg, seed_next;
    logic [1:0]        k_reg, k_next;
    logic [spxc_pkg::SWAP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        a_reg, a_next;
    logic [7:0]        b_reg, b_next;
    logic [15:0]       pos_reg, pos_next;
    logic [10:0]       prime_reg, prime_next;
    logic [7:0]        byte_reg, byte_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [7:0]        m_tdata_reg, m_tdata_next;

    spxc_pkg::perm_req_t req;
    logic [7:0]        rd_a;
    logic [7:0]        rd_b;

    logic              accept;
    logic [15:0]       pos_inc;
    logic [15:0]       key_prod_cur;
    logic [15:0]       key_prod_rom;
    logic [10:0]       rom_prime;
    logic [31:0]       seed_mix;
    logic [31:0]       seed_out;
    logic [31:0]       gx;
    logic [31:0]       gy;
    logic [31:0]       gw;

    spxc_perm_ram u_perm_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign s_tready = (state_reg == spxc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pos_inc      = pos_reg + 16'd1;
    assign rom_prime    = spxc_pkg::PRIME_ROM[rd_a];
    // only the low byte of prime * (position + 1) addresses the table
    assign key_prod_cur = prime_reg[7:0] * pos_inc[7:0];
    assign key_prod_rom = rom_prime[7:0] * pos_inc[7:0];

    assign seed_mix = seed_reg ^ (seed_reg >> 30);
    assign seed_out = 32'(seed_mix * spxc_pkg::SEED_MULT) + 32'({k_reg, 1'b0} >> 1) + 32'd1;

    always_comb
    begin
        gx = gen_reg[0] ^ (gen_reg[0] << 11);
        gx = gx ^ (gx >> 8);
        gy = gen_reg[3] ^ (gen_reg[3] >> 19);
        gw = gx ^ gy;
    end

    always_comb
    begin
        state_next    = state_reg;
        gen_next      = gen_reg;
        seed_next     = seed_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        pos_next      = pos_reg;
        prime_next    = prime_reg;
        byte_next     = byte_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        req           = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            spxc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == spxc_pkg::MODE_START)
                    begin
                        seed_next  = s_tdata[31:0];
                        k_next     = 2'd0;
                        pos_next   = 16'd0;
                        req.clear  = 1'b1;
                        state_next = spxc_pkg::ST_SEED;
                    end
                    else
                    begin
                        byte_next = s_tdata[39:32];
                        req.rd_en = 1'b1;
                        if (pos_reg[7:0] == 8'd0)
                        begin
                            req.rd_addr_a = pos_reg[15:8];
                            state_next    = spxc_pkg::ST_D_PRIME;
                        end
                        else
                        begin
                            req.rd_addr_b = key_prod_cur[7:0];
                            state_next    = spxc_pkg::ST_D_KEY;
                        end
                    end
                end
            end

            spxc_pkg::ST_SEED:
            begin
                gen_next[k_reg] = seed_out;
                seed_next       = seed_out;
                if (k_reg == 2'd2)
                begin
                    gen_next[3] = spxc_pkg::GEN_INIT3;
                    cnt_next    = '0;
                    state_next  = spxc_pkg::ST_DRAW;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            spxc_pkg::ST_DRAW:
            begin
                gen_next[0] = gen_reg[1];
                gen_next[1] = gen_reg[2];
                gen_next[2] = gen_reg[3];
                gen_next[3] = gw;
                a_next      = gw[7:0];
                b_next      = gw[15:8];
                if (gw[7:0] != gw[15:8])
                begin
                    req.rd_en     = 1'b1;
                    req.rd_addr_a = gw[7:0];
                    req.rd_addr_b = gw[15:8];
                    state_next    = spxc_pkg::ST_SWAP_A;
                end
                else
                begin
                    // equal bytes: no swap, count the draw
                    cnt_next = cnt_reg + 1'b1;
                    if (&cnt_reg)
                    begin
                        state_next = spxc_pkg::ST_IDLE;
                    end
                end
            end

            spxc_pkg::ST_SWAP_A:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = a_reg;
                req.wr_data = rd_b;
                state_next  = spxc_pkg::ST_SWAP_B;
            end

            spxc_pkg::ST_SWAP_B:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = b_reg;
                req.wr_data = rd_a;
                cnt_next    = cnt_reg + 1'b1;
                state_next  = (&cnt_reg) ? spxc_pkg::ST_IDLE : spxc_pkg::ST_DRAW;
            end

            spxc_pkg::ST_D_PRIME:
            begin
                prime_next    = rom_prime;
                req.rd_en     = 1'b1;
                req.rd_addr_b = key_prod_rom[7:0];
                state_next    = spxc_pkg::ST_D_KEY;
            end

            spxc_pkg::ST_D_KEY:
            begin
                // hold the key byte until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = byte_reg ^ rd_b;
                    pos_next      = pos_inc;
                    state_next    = spxc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spxc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spxc_pkg::ST_IDLE;
            gen_reg      <= '{default: 32'd0};
            k_reg        <= 2'd0;
            cnt_reg      <= '0;
            pos_reg      <= 16'd0;
            prime_reg    <= 11'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            gen_reg      <= gen_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            prime_reg    <= prime_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg    <= seed_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        byte_reg    <= byte_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef ASSERT_OFF
    a_wr_only_in_swap: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (state_reg == spxc_pkg::ST_SWAP_A || state_reg == spxc_pkg::ST_SWAP_B))
        else $error("permutation write outside a swap");

    a_key_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spxc_pkg::ST_D_KEY && m_tvalid_reg && !m_tready)
        |=> (state_reg == spxc_pkg::ST_D_KEY && $stable(m_tdata_reg)))
        else $error("result overwritten while output stalled");

    a_start_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == spxc_pkg::MODE_START) |=> (pos_reg == 16'd0))
        else $error("start item did not clear the byte position");

    a_pos_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spxc_pkg::ST_IDLE && !accept) |=> $stable(pos_reg))
        else $error("byte position moved without an item");
`endif

endmodule
